@@ src/ccd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ccd_pkg
// shared widths, angle constants and arctangent lookup for the cordic cosine
// ----------------------------------------------------------------------------
package ccd_pkg;

    localparam int DATA_WIDTH      = 16;
    localparam int OUT_WIDTH       = DATA_WIDTH + 2;
    localparam int ITERATIONS      = 11;
    localparam int ANGLE_WIDTH     = 8;
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int Z_WIDTH         = ANGLE_WIDTH + ANGLE_FRAC_BITS;

    localparam logic [ANGLE_WIDTH-1:0] HALF_TURN_DEG    = 8'd180;
    localparam logic [ANGLE_WIDTH-1:0] QUARTER_TURN_DEG = 8'd90;

    // largest residual angle magnitude, 90 degrees in 1/64 degree units
    localparam logic signed [Z_WIDTH-1:0] Z_LIMIT = 14'sd5760;

    // approximately arctan(2^-idx) in 1/64 degree units
    function automatic logic signed [Z_WIDTH-1:0] atan_lut(input int unsigned idx);
        logic signed [Z_WIDTH-1:0] v;
        case (idx)
            0:       v = 14'sd2880;
            1:       v = 14'sd1700;
            2:       v = 14'sd904;
            3:       v = 14'sd456;
            4:       v = 14'sd228;
            5:       v = 14'sd112;
            6:       v = 14'sd56;
            7:       v = 14'sd28;
            8:       v = 14'sd16;
            9:       v = 14'sd7;
            10:      v = 14'sd3;
            default: v = 14'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ src/cordic_cosine_degrees_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cordic_cosine_degrees_unit
// pipelined rotation-mode cordic returning magnitude times cos(angle)
// ----------------------------------------------------------------------------
// Takes an angle in whole degrees (values above 180 are treated as 180) and a
// signed 16-bit magnitude, and returns an 18-bit signed magnitude * cos(angle).
// The block is a fully unrolled pipeline: one prescale/fold stage, one stage per
// cordic rotation (eleven), and one output stage. A new item can be accepted in
// every cycle in which o_stall is low; an accepted item moves from the
// prescale/fold register through the rotation registers to the output register.
// Each stage moves forward whenever it is empty or the stage after it moves, so
// a stall at the output only holds back items until bubbles are used up. The
// magnitude is prescaled by 0.609375 to offset the cordic gain, so the overall
// gain is about 1.0035 and the result never leaves the output range.
// ----------------------------------------------------------------------------
module cordic_cosine_degrees_unit
    import ccd_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic        [ANGLE_WIDTH-1:0] i_angle_deg,
    input  wire logic signed [DATA_WIDTH-1:0]  i_magnitude,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed      [OUT_WIDTH-1:0]   o_cosine_scaled
);

    // stage s holds the item before rotation s; stage ITERATIONS is after the last
    logic        [ITERATIONS:0]     r_vld;
    logic signed [OUT_WIDTH-1:0]    r_x   [0:ITERATIONS];
    logic signed [OUT_WIDTH-1:0]    r_y   [0:ITERATIONS-1];
    logic signed [Z_WIDTH-1:0]      r_z   [0:ITERATIONS-1];
    logic        [ITERATIONS:0]     r_neg;

    // output register
    logic                           r_out_vld;
    logic signed [OUT_WIDTH-1:0]    r_out;

    // advance enables, one per stage, output stage at the top
    logic        [ITERATIONS+1:0]   w_adv;

    // front end: clamp, fold and prescale
    logic        [ANGLE_WIDTH-1:0]  w_ang_clamp;
    logic                           w_fold;
    logic        [ANGLE_WIDTH-1:0]  w_ang_fold;
    logic signed [OUT_WIDTH-1:0]    w_mag_ext;
    logic signed [OUT_WIDTH-1:0]    n_x0;
    logic signed [Z_WIDTH-1:0]      n_z0;
    logic signed [OUT_WIDTH-1:0]    n_out;

    // ------------------------------------------------------------------------
    // flow control: a stage moves when empty or when its successor moves
    // ------------------------------------------------------------------------
    assign w_adv[ITERATIONS+1] = !r_out_vld || !i_stall;

    for (genvar s = 0; s <= ITERATIONS; s++) begin : g_adv
        assign w_adv[s] = !r_vld[s] || w_adv[s+1];
    end

    assign o_stall = !w_adv[0];
    assign o_valid = r_out_vld;
    assign o_cosine_scaled = r_out;

    // ------------------------------------------------------------------------
    // stage 0: angle clamp and fold into 0..90, magnitude prescale by 0.609375
    // ------------------------------------------------------------------------
    always_comb begin
        w_ang_clamp = (i_angle_deg > HALF_TURN_DEG) ? HALF_TURN_DEG : i_angle_deg;
        // exactly 90 is not folded
        w_fold      = (w_ang_clamp > QUARTER_TURN_DEG);
        w_ang_fold  = w_fold ? (HALF_TURN_DEG - w_ang_clamp) : w_ang_clamp;
        n_z0        = {w_ang_fold, {ANGLE_FRAC_BITS{1'b0}}};
        w_mag_ext   = {{(OUT_WIDTH-DATA_WIDTH){i_magnitude[DATA_WIDTH-1]}}, i_magnitude};
        // 1/2 + 1/16 + 1/32 + 1/64, each term truncated toward minus infinity
        n_x0        = (w_mag_ext >>> 1) + (w_mag_ext >>> 4)
                    + (w_mag_ext >>> 5) + (w_mag_ext >>> 6);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_adv[0]) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_x[0]   <= n_x0;
            r_y[0]   <= '0;
            r_z[0]   <= n_z0;
            r_neg[0] <= w_fold;
        end
    end

    // ------------------------------------------------------------------------
    // rotation stages; the residual angle starts non-negative, so its sign
    // alone picks the direction and the first rotation is always positive
    // ------------------------------------------------------------------------
    for (genvar s = 0; s < ITERATIONS; s++) begin : g_rot
        logic                        w_neg_dir;
        logic signed [OUT_WIDTH-1:0] w_ys;
        logic signed [OUT_WIDTH-1:0] n_x;

        assign w_neg_dir = r_z[s][Z_WIDTH-1];
        assign w_ys      = r_y[s] >>> s;
        assign n_x       = w_neg_dir ? (r_x[s] + w_ys) : (r_x[s] - w_ys);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (w_adv[s+1]) begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv[s+1]) begin
                r_x[s+1]   <= n_x;
                r_neg[s+1] <= r_neg[s];
            end
        end

        // y and the residual angle are not needed after the last rotation
        if (s < ITERATIONS - 1) begin : g_yz
            logic signed [OUT_WIDTH-1:0] w_xs;
            logic signed [OUT_WIDTH-1:0] n_y;
            logic signed [Z_WIDTH-1:0]   n_z;

            assign w_xs = r_x[s] >>> s;
            assign n_y  = w_neg_dir ? (r_y[s] - w_xs) : (r_y[s] + w_xs);
            assign n_z  = w_neg_dir ? (r_z[s] + atan_lut(s)) : (r_z[s] - atan_lut(s));

            always_ff @(posedge i_clk) begin
                if (w_adv[s+1]) begin
                    r_y[s+1] <= n_y;
                    r_z[s+1] <= n_z;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // output stage: undo the fold by negating; gain keeps it inside the range
    // ------------------------------------------------------------------------
    assign n_out = r_neg[ITERATIONS] ? -r_x[ITERATIONS] : r_x[ITERATIONS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv[ITERATIONS+1]) begin
            r_out_vld <= r_vld[ITERATIONS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[ITERATIONS+1]) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    // input is held back only when every stage is full and the output is stalled
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_vld && i_stall && (&r_vld)))
        else $error("input stalled while pipeline has room");

    // folded angle entering the rotations stays within 0..90 degrees
    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_z[0] >= 0 && r_z[0] <= Z_LIMIT))
        else $error("folded angle out of range");

    // residual angle at the last rotation stays bounded
    a_residual_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ITERATIONS-1] |-> (r_z[ITERATIONS-1] >= -Z_LIMIT
                                 && r_z[ITERATIONS-1] <= Z_LIMIT))
        else $error("residual angle diverged");
`endif

endmodule
`default_nettype wire
